// ----- sv/wal_pkg.sv -----
// ----------------------------------------------------------------------------
// wal_pkg
// Shared types and constants of the write-ahead log controller: result kinds,
// register indexes, sequencer states and the records between its modules.
// ----------------------------------------------------------------------------
package wal_pkg;

	localparam int LOG_ENTRIES_DEF = 16;
	localparam int CNT_W = 5;
	localparam int ADDR_W = 32;
	localparam int KIND_W = 4;
	localparam int ACT_W = 2;
	localparam int CFG_IDX_W = 2;

	localparam logic [CNT_W-1:0] OPS_MAX = 5'd31;

	// action codes
	localparam logic [ACT_W-1:0] ACT_BEGIN = 2'd0;
	localparam logic [ACT_W-1:0] ACT_END = 2'd1;
	localparam logic [ACT_W-1:0] ACT_WRITE = 2'd2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_LOG_START = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LOG_SIZE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_OPS_RESERVE = 2'd2;

	localparam logic [CNT_W-1:0] LOG_SIZE_RST = 5'd16;
	localparam logic [CNT_W-1:0] OPS_RESERVE_RST = 5'd4;

	typedef enum logic [KIND_W-1:0] {
		K_GRANT = 4'd0,
		K_WAIT = 4'd1,
		K_END = 4'd2,
		K_ABSORB = 4'd3,
		K_ADD = 4'd4,
		K_COPY = 4'd5,
		K_HEAD = 4'd6,
		K_INSTALL = 4'd7,
		K_CLEAR = 4'd8,
		K_ERROR = 4'd9
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_SEARCH,
		ST_COPY,
		ST_HEAD,
		ST_INSTALL,
		ST_CLEAR
	} state_t;

	typedef struct packed {
		logic [ADDR_W-1:0] log_start;
		logic [CNT_W-1:0] log_size;
		logic [CNT_W-1:0] ops_reserve;
	} cfg_t;

	typedef struct packed {
		logic we;
		logic [CNT_W-1:0] idx;
		logic [ADDR_W-1:0] key;
	} tbl_req_t;

	typedef struct packed {
		logic hit;
		logic [ADDR_W-1:0] data;
	} tbl_rsp_t;

endpackage

// ----- sv/wal_table.sv -----
// ----------------------------------------------------------------------------
// wal_table
// Block number table with one write port and one read port on a shared
// index, and the shared equality compare used by the sequential search.
// ----------------------------------------------------------------------------
module wal_table #(
	parameter int LOG_ENTRIES = wal_pkg::LOG_ENTRIES_DEF
) (
	input  logic              clk,
	input  wal_pkg::tbl_req_t req,
	output wal_pkg::tbl_rsp_t rsp
);

	localparam int IDX_W = (LOG_ENTRIES > 1) ? $clog2(LOG_ENTRIES) : 1;

	logic [wal_pkg::ADDR_W-1:0] table_q [LOG_ENTRIES];
	logic [IDX_W-1:0] idx;

	assign idx = req.idx[IDX_W-1:0];

	always_ff @(posedge clk) begin
		if (req.we) begin
			table_q[idx] <= req.key;
		end
	end

	assign rsp.data = table_q[idx];
	assign rsp.hit = (table_q[idx] == req.key);

endmodule

// ----- sv/wal_ctrl.sv -----
// ----------------------------------------------------------------------------
// wal_ctrl
// Sequencer of the log controller: admission, table search, commit run and
// the output register.
// ----------------------------------------------------------------------------
module wal_ctrl #(
	parameter int LOG_ENTRIES = wal_pkg::LOG_ENTRIES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  wal_pkg::cfg_t               cfg,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [wal_pkg::ACT_W-1:0]   action,
	input  logic [wal_pkg::ADDR_W-1:0]  block_number,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [wal_pkg::KIND_W-1:0]  kind,
	output logic [wal_pkg::ADDR_W-1:0]  home_block,
	output logic [wal_pkg::ADDR_W-1:0]  log_block,
	output logic [wal_pkg::CNT_W-1:0]   head_count,
	output logic                        last,
	output wal_pkg::tbl_req_t           tbl_req,
	input  wal_pkg::tbl_rsp_t           tbl_rsp
);

	localparam logic [wal_pkg::CNT_W-1:0] ENTRIES = wal_pkg::CNT_W'(LOG_ENTRIES);

	wal_pkg::state_t state_q, state_d;
	logic [wal_pkg::ACT_W-1:0] act_q;
	logic [wal_pkg::ADDR_W-1:0] blk_q;
	logic [wal_pkg::CNT_W-1:0] idx_q, idx_d;
	logic [wal_pkg::CNT_W-1:0] cnt_q, cnt_d;
	logic [wal_pkg::CNT_W-1:0] ops_q, ops_d;

	logic out_valid_q;
	wal_pkg::kind_t kind_q, kind_d;
	logic [wal_pkg::ADDR_W-1:0] home_q, home_d;
	logic [wal_pkg::ADDR_W-1:0] lblk_q, lblk_d;
	logic [wal_pkg::CNT_W-1:0] hcnt_q, hcnt_d;
	logic last_q, last_d;
	logic emit;
	logic out_free;

	logic [wal_pkg::CNT_W-1:0] cap;
	logic [10:0] prod;
	logic [11:0] need;
	logic [wal_pkg::ADDR_W-1:0] slot_addr;
	logic idx_end;

	assign cap = (cfg.log_size < ENTRIES) ? cfg.log_size : ENTRIES;
	assign prod = 11'({1'b0, ops_q} + 6'd1) * 11'(cfg.ops_reserve);
	assign need = 12'(prod) + 12'(cnt_q);
	assign slot_addr = cfg.log_start + wal_pkg::ADDR_W'(idx_q) + 32'd1;
	assign idx_end = (idx_q == cnt_q - 5'd1);

	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == wal_pkg::ST_IDLE);

	always_comb begin
		state_d = state_q;
		idx_d = idx_q;
		cnt_d = cnt_q;
		ops_d = ops_q;
		emit = 1'b0;
		kind_d = wal_pkg::K_ERROR;
		home_d = '0;
		lblk_d = '0;
		hcnt_d = '0;
		last_d = 1'b1;
		tbl_req.we = 1'b0;
		tbl_req.idx = idx_q;
		tbl_req.key = blk_q;
		unique case (state_q)
			wal_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_d = wal_pkg::ST_EXEC;
				end
			end
			wal_pkg::ST_EXEC: begin
				idx_d = '0;
				if (out_free) begin
					unique case (act_q)
						wal_pkg::ACT_BEGIN: begin
							emit = 1'b1;
							state_d = wal_pkg::ST_IDLE;
							if (ops_q >= wal_pkg::OPS_MAX || need > 12'(cap)) begin
								kind_d = wal_pkg::K_WAIT;
							end else begin
								kind_d = wal_pkg::K_GRANT;
								ops_d = ops_q + 5'd1;
							end
						end
						wal_pkg::ACT_END: begin
							if (ops_q == '0) begin
								emit = 1'b1;
								state_d = wal_pkg::ST_IDLE;
							end else begin
								ops_d = ops_q - 5'd1;
								if (ops_q != 5'd1 || cnt_q == '0) begin
									emit = 1'b1;
									kind_d = wal_pkg::K_END;
									state_d = wal_pkg::ST_IDLE;
								end else begin
									state_d = wal_pkg::ST_COPY;
								end
							end
						end
						wal_pkg::ACT_WRITE: begin
							if (cnt_q >= cap || ops_q == '0) begin
								emit = 1'b1;
								state_d = wal_pkg::ST_IDLE;
							end else begin
								state_d = wal_pkg::ST_SEARCH;
							end
						end
						default: begin
							emit = 1'b1;
							state_d = wal_pkg::ST_IDLE;
						end
					endcase
				end
			end
			wal_pkg::ST_SEARCH: begin
				home_d = blk_q;
				lblk_d = slot_addr;
				if (idx_q == cnt_q) begin
					if (out_free) begin
						emit = 1'b1;
						kind_d = wal_pkg::K_ADD;
						tbl_req.we = 1'b1;
						cnt_d = idx_q + 5'd1;
						state_d = wal_pkg::ST_IDLE;
					end
				end else if (tbl_rsp.hit) begin
					if (out_free) begin
						emit = 1'b1;
						kind_d = wal_pkg::K_ABSORB;
						state_d = wal_pkg::ST_IDLE;
					end
				end else begin
					idx_d = idx_q + 5'd1;
				end
			end
			wal_pkg::ST_COPY: begin
				kind_d = wal_pkg::K_COPY;
				home_d = tbl_rsp.data;
				lblk_d = slot_addr;
				last_d = 1'b0;
				if (out_free) begin
					emit = 1'b1;
					if (idx_end) begin
						idx_d = '0;
						state_d = wal_pkg::ST_HEAD;
					end else begin
						idx_d = idx_q + 5'd1;
					end
				end
			end
			wal_pkg::ST_HEAD: begin
				kind_d = wal_pkg::K_HEAD;
				lblk_d = cfg.log_start;
				hcnt_d = cnt_q;
				last_d = 1'b0;
				if (out_free) begin
					emit = 1'b1;
					state_d = wal_pkg::ST_INSTALL;
				end
			end
			wal_pkg::ST_INSTALL: begin
				kind_d = wal_pkg::K_INSTALL;
				home_d = tbl_rsp.data;
				lblk_d = slot_addr;
				last_d = 1'b0;
				if (out_free) begin
					emit = 1'b1;
					if (idx_end) begin
						state_d = wal_pkg::ST_CLEAR;
					end else begin
						idx_d = idx_q + 5'd1;
					end
				end
			end
			wal_pkg::ST_CLEAR: begin
				kind_d = wal_pkg::K_CLEAR;
				lblk_d = cfg.log_start;
				if (out_free) begin
					emit = 1'b1;
					cnt_d = '0;
					state_d = wal_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = wal_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= wal_pkg::ST_IDLE;
			idx_q <= '0;
			cnt_q <= '0;
			ops_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			idx_q <= idx_d;
			cnt_q <= cnt_d;
			ops_q <= ops_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			act_q <= action;
			blk_q <= block_number;
		end
		if (emit) begin
			kind_q <= kind_d;
			home_q <= home_d;
			lblk_q <= lblk_d;
			hcnt_q <= hcnt_d;
			last_q <= last_d;
		end
	end

	assign out_valid = out_valid_q;
	assign kind = kind_q;
	assign home_block = home_q;
	assign log_block = lblk_q;
	assign head_count = hcnt_q;
	assign last = last_q;

endmodule

// ----- sv/write_ahead_log_controller_unit.sv -----
// ----------------------------------------------------------------------------
// write_ahead_log_controller_unit
// Journaling log controller with group commit: admits operations, collects
// logged block numbers and emits the commit run when the last one ends.
// ----------------------------------------------------------------------------
// Channels: an input channel (action, block_number), a result channel
// (kind, home_block, log_block, head_count, last) and a register write
// channel (cfg_index, cfg_data), each a valid/ready transfer.
// One input item is taken at a time; in_ready is high only while the
// sequencer is idle. Every item gives one or more results, the final one
// flagged by last.
// Begin, end and error items are decoded in the exec state, and their result
// is held in the output register. A write walks the table one entry a cycle
// through a single comparator. A final end with n entries gives 2*n + 2
// results, one per cycle while the receiver is ready; the copy and install
// results are addressed by one shared slot adder.
// A stalled receiver holds the output register and the sequencer waits
// in place; nothing is dropped. Register writes are always taken.
// Reset clears the entry and operation counts and loads the register
// defaults; the table needs no clearing since only filled entries are read.
module write_ahead_log_controller_unit #(
	parameter int LOG_ENTRIES = wal_pkg::LOG_ENTRIES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [wal_pkg::ACT_W-1:0]     action,
	input  logic [wal_pkg::ADDR_W-1:0]    block_number,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [wal_pkg::KIND_W-1:0]    kind,
	output logic [wal_pkg::ADDR_W-1:0]    home_block,
	output logic [wal_pkg::ADDR_W-1:0]    log_block,
	output logic [wal_pkg::CNT_W-1:0]     head_count,
	output logic                          last,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [wal_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [wal_pkg::ADDR_W-1:0]    cfg_data
);

	wal_pkg::cfg_t cfg_q;
	wal_pkg::tbl_req_t tbl_req;
	wal_pkg::tbl_rsp_t tbl_rsp;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.log_start <= '0;
			cfg_q.log_size <= wal_pkg::LOG_SIZE_RST;
			cfg_q.ops_reserve <= wal_pkg::OPS_RESERVE_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				wal_pkg::REG_LOG_START: cfg_q.log_start <= cfg_data;
				wal_pkg::REG_LOG_SIZE: cfg_q.log_size <= cfg_data[wal_pkg::CNT_W-1:0];
				wal_pkg::REG_OPS_RESERVE: cfg_q.ops_reserve <= cfg_data[wal_pkg::CNT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	wal_ctrl #(
		.LOG_ENTRIES(LOG_ENTRIES)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.action(action),
		.block_number(block_number),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.kind(kind),
		.home_block(home_block),
		.log_block(log_block),
		.head_count(head_count),
		.last(last),
		.tbl_req(tbl_req),
		.tbl_rsp(tbl_rsp)
	);

	wal_table #(
		.LOG_ENTRIES(LOG_ENTRIES)
	) u_table (
		.clk(clk),
		.req(tbl_req),
		.rsp(tbl_rsp)
	);

endmodule

// ----- sv/wal_checker.sv -----
// ----------------------------------------------------------------------------
// wal_checker
// Port-level checks of the log controller, bound to the top level.
// ----------------------------------------------------------------------------
module wal_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [wal_pkg::KIND_W-1:0]    kind,
	input logic [wal_pkg::ADDR_W-1:0]    home_block,
	input logic [wal_pkg::CNT_W-1:0]     head_count,
	input logic                          last
);

	// held result stays put while stalled
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(home_block)
			&& $stable(last))
		else $error("result changed while stalled");

	// one item at a time
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second item taken while busy");

	// commit run kinds are never final
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind == wal_pkg::K_COPY || kind == wal_pkg::K_HEAD
			|| kind == wal_pkg::K_INSTALL) |-> !last)
		else $error("commit run ended early");

	// single-result kinds and the clear always close their item
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind == wal_pkg::K_GRANT || kind == wal_pkg::K_WAIT
			|| kind == wal_pkg::K_END || kind == wal_pkg::K_ERROR
			|| kind == wal_pkg::K_ABSORB || kind == wal_pkg::K_ADD
			|| kind == wal_pkg::K_CLEAR) |-> last)
		else $error("missing last flag");

	// header write carries a non-empty count
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == wal_pkg::K_HEAD |-> head_count != '0)
		else $error("empty header written");

endmodule

bind write_ahead_log_controller_unit wal_checker u_wal_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(in_valid),
	.in_ready(in_ready),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.kind(kind),
	.home_block(home_block),
	.head_count(head_count),
	.last(last)
);
